// ===== sv/bmi_pkg.sv =====
// Shared constants and status codes for the binary modular inverse unit.
package bmi_pkg;

    // Default working width of u, v, r and s
    localparam int unsigned DEF_WIDTH = 32;

    // External field widths
    localparam int unsigned MOD_W  = 32;
    localparam int unsigned OPND_W = 32;
    localparam int unsigned INV_W  = 32;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned ADDR_W = 3;

    // Modulus register value after reset
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(3);

    // Halving counter saturates here
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_NOINV = 2'd2;

    // Register word index of the modulus (paddr bit 2 up)
    localparam logic REG_MODULUS = 1'b0;

endpackage

// ===== sv/bmi_step.sv =====
// A binary extended Euclid step: a halver each for u/v and r/s; a shared r/s subtractor.
module bmi_step #(
    parameter int unsigned WIDTH = bmi_pkg::DEF_WIDTH
) (
    input  logic [WIDTH-1:0] i_p,
    input  logic [WIDTH-1:0] i_u,
    input  logic [WIDTH-1:0] i_v,
    input  logic [WIDTH-1:0] i_r,
    input  logic [WIDTH-1:0] i_s,
    output logic [WIDTH-1:0] o_u,
    output logic [WIDTH-1:0] o_v,
    output logic [WIDTH-1:0] o_r,
    output logic [WIDTH-1:0] o_s,
    output logic             o_halved
);
    import bmi_pkg::*;

    logic             u_even;
    logic             v_even;
    logic             halve;
    logic [WIDTH-1:0] sh_src;
    logic [WIDTH-1:0] sh_res;
    logic [WIDTH-1:0] hm_src;
    logic [WIDTH-1:0] hm_res;
    logic [WIDTH:0]   d_uv;
    logic [WIDTH:0]   d_vu;
    logic             u_gt_v;
    logic [WIDTH-1:0] sm_x;
    logic [WIDTH-1:0] sm_y;
    logic [WIDTH:0]   sm_d;
    logic [WIDTH-1:0] sm_res;

    assign u_even = ~i_u[0];
    assign v_even = ~i_v[0];
    assign halve  = u_even | v_even;

    // Shared plain halver for u or v
    assign sh_src = u_even ? i_u : i_v;
    assign sh_res = sh_src >> 1;

    // Shared modular halver for r or s: (x + p) / 2 when x is odd
    assign hm_src = u_even ? i_r : i_s;
    assign hm_res = hm_src[0] ? (hm_src >> 1) + (i_p >> 1) + WIDTH'(1) : (hm_src >> 1);

    // Compare by borrow of u - v
    assign d_uv   = {1'b0, i_u} - {1'b0, i_v};
    assign d_vu   = {1'b0, i_v} - {1'b0, i_u};
    assign u_gt_v = ~d_uv[WIDTH] && (d_uv != '0);

    // Shared modular subtractor: x - y, wrapped by p on borrow
    assign sm_x   = u_gt_v ? i_r : i_s;
    assign sm_y   = u_gt_v ? i_s : i_r;
    assign sm_d   = {1'b0, sm_x} - {1'b0, sm_y};
    assign sm_res = sm_d[WIDTH] ? sm_d[WIDTH-1:0] + i_p : sm_d[WIDTH-1:0];

    // Next working values
    always_comb begin
        o_u = i_u;
        o_v = i_v;
        o_r = i_r;
        o_s = i_s;
        if (u_even) begin
            o_u = sh_res;
            o_r = hm_res;
        end else if (v_even) begin
            o_v = sh_res;
            o_s = hm_res;
        end else if (u_gt_v) begin
            o_u = d_uv[WIDTH-1:0];
            o_r = sm_res;
        end else begin
            o_v = d_vu[WIDTH-1:0];
            o_s = sm_res;
        end
    end

    assign o_halved = halve;

endmodule

// ===== sv/binary_modular_inverse_unit.sv =====
// Top level of the binary modular inverse unit: config port, sequencer and result register.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------------------------------
//  request  | i_in_valid / o_in_ready          | i_operand[31:0]
//  result   | o_out_valid / i_out_ready        | o_inverse[31:0], o_halving_count[6:0],
//           |                                  | o_status[1:0]
//  config   | psel, penable, pwrite, pready    | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A request that is rejected early (operand out of range or even modulus) skips the Euclid
// loop and goes straight to the finish step; otherwise the loop runs until v reaches zero.
// The loop is a single shared step unit, one step per cycle.
// Reset is synchronous, active low, and sets the modulus to 3.
// o_in_ready is high only while idle; a finished result waits in the output register while
// the next request is taken, and the finish step stalls only if that register is still full.
module binary_modular_inverse_unit #(
    parameter int unsigned WIDTH = bmi_pkg::DEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmi_pkg::ADDR_W-1:0]   paddr,
    input  logic [bmi_pkg::MOD_W-1:0]    pwdata,
    output logic [bmi_pkg::MOD_W-1:0]    prdata,
    output logic                         pready,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bmi_pkg::OPND_W-1:0]   i_operand,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bmi_pkg::INV_W-1:0]    o_inverse,
    output logic [bmi_pkg::CNT_W-1:0]    o_halving_count,
    output logic [bmi_pkg::ST_W-1:0]     o_status
);
    import bmi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [MOD_W-1:0] r_modulus;
    logic [WIDTH-1:0] r_u, n_u;
    logic [WIDTH-1:0] r_v, n_v;
    logic [WIDTH-1:0] r_r, n_r;
    logic [WIDTH-1:0] r_s, n_s;
    logic [CNT_W-1:0] r_k, n_k;
    logic [ST_W-1:0]  r_st, n_st;
    logic             r_out_valid, n_out_valid;
    logic [INV_W-1:0] r_inv, n_inv;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ST_W-1:0]  r_ost, n_ost;

    logic [WIDTH-1:0] p;
    logic [WIDTH-1:0] a;
    logic             in_acc;
    logic             cfg_wr;
    logic [WIDTH-1:0] st_u;
    logic [WIDTH-1:0] st_v;
    logic [WIDTH-1:0] st_r;
    logic [WIDTH-1:0] st_s;
    logic             st_halved;

    // Configuration port: always ready, single modulus register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_MODULUS);
    assign prdata = (paddr[2] == REG_MODULUS) ? r_modulus : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (cfg_wr) begin
            r_modulus <= pwdata;
        end
    end

    // Working operands at WIDTH bits
    assign p = WIDTH'(r_modulus);
    assign a = WIDTH'(i_operand);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;

    bmi_step #(
        .WIDTH (WIDTH)
    ) u_step (
        .i_p      (p),
        .i_u      (r_u),
        .i_v      (r_v),
        .i_r      (r_r),
        .i_s      (r_s),
        .o_u      (st_u),
        .o_v      (st_v),
        .o_r      (st_r),
        .o_s      (st_s),
        .o_halved (st_halved)
    );

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_u         = r_u;
        n_v         = r_v;
        n_r         = r_r;
        n_s         = r_s;
        n_k         = r_k;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_inv       = r_inv;
        n_cnt       = r_cnt;
        n_ost       = r_ost;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_k  = '0;
                    n_r  = '0;
                    n_u  = p;
                    n_v  = a;
                    n_s  = (p == WIDTH'(1)) ? '0 : WIDTH'(1);
                    n_st = ST_OK;
                    if ((a == '0) || (a > p)) begin
                        n_st    = ST_RANGE;
                        n_state = S_FIN;
                    end else if (!p[0]) begin
                        n_st    = ST_NOINV;
                        n_r     = '0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_v == '0) begin
                    // loop done: u holds the gcd
                    if (r_u != WIDTH'(1)) begin
                        n_st = ST_NOINV;
                        n_r  = '0;
                    end
                    n_state = S_FIN;
                end else begin
                    n_u = st_u;
                    n_v = st_v;
                    n_r = st_r;
                    n_s = st_s;
                    if (st_halved && (r_k != CNT_MAX)) begin
                        n_k = r_k + CNT_W'(1);
                    end
                end
            end
            S_FIN: begin
                // move the result into the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_inv       = INV_W'(r_r);
                    n_cnt       = r_k;
                    n_ost       = r_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_r   <= n_r;
        r_s   <= n_s;
        r_k   <= n_k;
        r_st  <= n_st;
        r_inv <= n_inv;
        r_cnt <= n_cnt;
        r_ost <= n_ost;
    end

    assign o_out_valid     = r_out_valid;
    assign o_inverse       = r_inv;
    assign o_halving_count = r_cnt;
    assign o_status        = r_ost;

endmodule
